// File: sv/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies; used by every module of the block.
package pfe_pkg;

    // Word width of stack entries and arithmetic
    localparam int DATA_W = 32;
    // Default operand stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // ASCII codes of interest
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_DIV   = 8'h2F;

    // Error codes reported with each result
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_UNDER   = 3'd1,
        ERR_OVER    = 3'd2,
        ERR_DIVZERO = 3'd3,
        ERR_SYMBOL  = 3'd4
    } error_t;

    // Per-cell shift command
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_UPPER,
        CELL_TAKE_LOWER
    } cell_op_t;

    // Control state of the evaluator
    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: sv/pfe_cell.sv
// One operand stack cell: a 32-bit entry that loads from its upper or lower neighbor.
// Depends on pfe_pkg.
module pfe_cell
(
    input  logic                      clk,
    input  pfe_pkg::cell_op_t         op,
    input  logic [pfe_pkg::DATA_W-1:0] upper,
    input  logic [pfe_pkg::DATA_W-1:0] lower,
    output logic [pfe_pkg::DATA_W-1:0] q
);

    logic [pfe_pkg::DATA_W-1:0] data_reg;
    logic [pfe_pkg::DATA_W-1:0] data_next;

    // Push shifts down, pop shifts up
    always_comb
    begin
        case (op)
            pfe_pkg::CELL_TAKE_UPPER: data_next = upper;
            pfe_pkg::CELL_TAKE_LOWER: data_next = lower;
            default:                  data_next = data_reg;
        endcase
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// File: sv/pfe_divider.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on pfe_pkg (word width, request/response structs).
module pfe_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  pfe_pkg::div_req_t req,
    output pfe_pkg::div_rsp_t rsp
);

    localparam int W     = pfe_pkg::DATA_W;
    localparam int ITER_W = $clog2(W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [W-1:0]      dvs_reg, dvs_next;
    logic              neg_reg, neg_next;

    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         ge;

    // Restoring step: shift in next dividend bit, trial subtract
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~diff[W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            // Latch magnitudes and result sign
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
            dvs_next  = req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
            neg_next  = req.dividend[W-1] ^ req.divisor[W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[W-1:0] : shifted[W-1:0];
            quo_next  = {quo_reg[W-2:0], ge};
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// File: sv/postfix_expression_evaluator_unit.sv
// Postfix evaluator: one ASCII symbol per transfer; digits, + - * / on a cell-chain stack.
// Digits and + - * update the stack when accepted; '/' runs in the bit-serial divider.
// A result is valid in the cycle after the last symbol is accepted; after a final '/', once the divider is done.
// Throughput: one symbol per cycle; input stalls while a '/' divides and while a result waits.
// Reset clears control, stack count, sticky error and output valid; stack cells keep data.
// Depends on pfe_pkg, pfe_cell and pfe_divider.
module postfix_expression_evaluator_unit
#(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] value, [34:32] error, [39:35] zero
);

    localparam int W     = pfe_pkg::DATA_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    pfe_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    pfe_pkg::error_t  err_reg, err_next;
    logic             last_pend_reg, last_pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_value_reg, out_value_next;
    pfe_pkg::error_t  out_err_reg, out_err_next;

    logic [W-1:0] cell_q [STACK_DEPTH];
    pfe_pkg::cell_op_t op_top, op_rest;

    pfe_pkg::div_req_t div_req;
    pfe_pkg::div_rsp_t div_rsp;

    logic             s_fire;
    logic             push, combine, item_done, last_sel, fin_last;
    logic [W-1:0]     new_top, top_upd, alu_res;
    logic [CNT_W-1:0] cnt_upd;
    pfe_pkg::error_t  err_upd, fin_err;
    logic [7:0]       digit_off;
    logic             is_digit, is_op, is_div;

    assign s_axis_tready = (state_reg == pfe_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Symbol decode
    assign digit_off = s_axis_tdata - pfe_pkg::SYM_ZERO;
    assign is_digit  = (s_axis_tdata >= pfe_pkg::SYM_ZERO) && (s_axis_tdata <= pfe_pkg::SYM_NINE);
    assign is_div    = (s_axis_tdata == pfe_pkg::SYM_DIV);

    // ALU over the two top cells: left below, right on top
    always_comb
    begin
        is_op   = 1'b1;
        alu_res = '0;
        case (s_axis_tdata)
            pfe_pkg::SYM_PLUS:  alu_res = cell_q[1] + cell_q[0];
            pfe_pkg::SYM_MINUS: alu_res = cell_q[1] - cell_q[0];
            pfe_pkg::SYM_MUL:   alu_res = W'(cell_q[1] * cell_q[0]);
            pfe_pkg::SYM_DIV:   alu_res = '0;
            default:            is_op = 1'b0;
        endcase
    end

    // Item processing and control
    always_comb
    begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        push           = 1'b0;
        combine        = 1'b0;
        item_done      = 1'b0;
        last_sel       = 1'b0;
        new_top        = alu_res;
        cnt_upd        = count_reg;
        err_upd        = err_reg;
        div_req.start    = 1'b0;
        div_req.dividend = cell_q[1];
        div_req.divisor  = cell_q[0];

        unique case (state_reg)
            pfe_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    item_done = 1'b1;
                    last_sel  = s_axis_tlast;
                    if (err_reg != pfe_pkg::ERR_NONE)
                    begin
                        // sticky error: symbol ignored
                    end
                    else if (is_digit)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                            err_upd = pfe_pkg::ERR_OVER;
                        else
                        begin
                            push    = 1'b1;
                            new_top = {{(W-4){1'b0}}, digit_off[3:0]};
                            cnt_upd = count_reg + CNT_W'(1);
                        end
                    end
                    else if (!is_op)
                        err_upd = pfe_pkg::ERR_SYMBOL;
                    else if (count_reg < CNT_W'(2))
                        err_upd = pfe_pkg::ERR_UNDER;
                    else if (is_div)
                    begin
                        if (cell_q[0] == '0)
                            err_upd = pfe_pkg::ERR_DIVZERO;
                        else
                        begin
                            div_req.start  = 1'b1;
                            item_done      = 1'b0;
                            last_pend_next = s_axis_tlast;
                            state_next     = pfe_pkg::ST_DIV;
                        end
                    end
                    else
                    begin
                        combine = 1'b1;
                        cnt_upd = count_reg - CNT_W'(1);
                    end
                end
            end
            pfe_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    combine    = 1'b1;
                    new_top    = div_rsp.quotient;
                    cnt_upd    = count_reg - CNT_W'(1);
                    item_done  = 1'b1;
                    last_sel   = last_pend_reg;
                    state_next = pfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase

        // Result of a finished expression
        fin_last = item_done && last_sel;
        top_upd  = (push || combine) ? new_top : cell_q[0];
        if (err_upd != pfe_pkg::ERR_NONE)
            fin_err = err_upd;
        else if (cnt_upd == '0)
            fin_err = pfe_pkg::ERR_UNDER;
        else
            fin_err = pfe_pkg::ERR_NONE;

        count_next = fin_last ? '0 : cnt_upd;
        err_next   = fin_last ? pfe_pkg::ERR_NONE : err_upd;

        // Output register
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        if (fin_last)
        begin
            out_valid_next = 1'b1;
            out_err_next   = fin_err;
            out_value_next = (fin_err == pfe_pkg::ERR_NONE) ? top_upd : '0;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        // Cell commands
        op_top  = (push || combine) ? pfe_pkg::CELL_TAKE_UPPER : pfe_pkg::CELL_HOLD;
        op_rest = push ? pfe_pkg::CELL_TAKE_UPPER :
                  (combine ? pfe_pkg::CELL_TAKE_LOWER : pfe_pkg::CELL_HOLD);
    end

    // Operand stack: top of stack in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [W-1:0] upper_in;
            logic [W-1:0] lower_in;
            if (gi == 0)
            begin : g_first
                assign upper_in = new_top;
            end
            else
            begin : g_mid
                assign upper_in = cell_q[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_last
                assign lower_in = '0;
            end
            else
            begin : g_inner
                assign lower_in = cell_q[gi+1];
            end
            pfe_cell u_cell
            (
                .clk   (clk),
                .op    ((gi == 0) ? op_top : op_rest),
                .upper (upper_in),
                .lower (lower_in),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    // Divider
    pfe_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfe_pkg::ST_IDLE;
            count_reg     <= '0;
            err_reg       <= pfe_pkg::ERR_NONE;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_err_reg, out_value_reg};

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfe_pkg::ST_DIV |-> count_reg >= CNT_W'(2))
        else $error("division running without two operands");

    a_div_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfe_pkg::ST_DIV |-> !s_axis_tready)
        else $error("input accepted during division");

    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_err_reg != pfe_pkg::ERR_NONE |-> out_value_reg == '0)
        else $error("error result carries nonzero value");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && s_axis_tlast && !div_req.start |=> count_reg == '0 && m_axis_tvalid)
        else $error("stack not cleared after last symbol");

endmodule
